### hw/rtl/rsa_me_pkg.sv
// shared constants and controller/datapath interface types for the rsa exponentiation core
package rsa_me_pkg;

  localparam int DEF_WORD_BITS = 64;

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_PUB_EXP  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PRIV_EXP = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = 2'd2;

  localparam logic [63:0] RESET_PUB_EXP  = 64'd65537;
  localparam logic [63:0] RESET_PRIV_EXP = 64'd0;
  localparam logic [63:0] RESET_MODULUS  = 64'd2;

  typedef struct packed {
    logic load;
    logic red_step;
    logic red_done;
    logic mul_start;
    logic mul_sqr;
    logic mul_step;
    logic wr_acc;
    logic wr_base;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic ex_bit;
    logic n_small;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/rsa_me_ctrl.sv
// sequencer for reduction, square-and-multiply and result hand-off
module rsa_me_ctrl #(
  parameter int WORD_BITS = rsa_me_pkg::DEF_WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  rsa_me_pkg::dp_status_t status,
  output logic                   busy_n,
  output rsa_me_pkg::dp_cmd_t    cmd
);
  import rsa_me_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_EXP  = 6'b000100,
    S_MACC = 6'b001000,
    S_MSQ  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] step_cnt, step_cnt_next;
  logic [CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic             cnt_last, bit_last;

  assign cnt_last = (step_cnt == CNT_LAST);
  assign bit_last = (bit_cnt == CNT_LAST);
  assign busy_n   = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    bit_cnt_next  = bit_cnt;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          step_cnt_next = '0;
          bit_cnt_next  = '0;
          state_next    = status.n_small ? S_FIN : S_RED;
        end
      end
      S_RED: begin
        cmd.red_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (cnt_last) begin
          cmd.red_done  = 1'b1;
          step_cnt_next = '0;
          state_next    = S_EXP;
        end
      end
      S_EXP: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sqr   = !status.ex_bit;
        state_next    = status.ex_bit ? S_MACC : S_MSQ;
      end
      S_MACC: begin
        cmd.mul_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (cnt_last) begin
          cmd.wr_acc    = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sqr   = 1'b1;
          step_cnt_next = '0;
          state_next    = S_MSQ;
        end
      end
      S_MSQ: begin
        cmd.mul_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (cnt_last) begin
          cmd.wr_base   = 1'b1;
          step_cnt_next = '0;
          bit_cnt_next  = bit_cnt + 1'b1;
          state_next    = bit_last ? S_FIN : S_EXP;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
      bit_cnt  <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      bit_cnt  <= bit_cnt_next;
    end
  end

  a_red_to_exp: assert property (@(posedge clk) disable iff (rst)
    (state == S_RED && cnt_last) |=> (state == S_EXP))
    else $error("reduction did not hand over to the exponent scan");

  a_last_bit_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_MSQ && cnt_last && bit_last) |=> (state == S_FIN))
    else $error("exponent scan did not end after the last bit");

  a_bit_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && !(state == S_MSQ && cnt_last)) |=> $stable(bit_cnt))
    else $error("exponent bit counter moved outside a squaring end");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !start) |=> (state == S_IDLE))
    else $error("controller left idle without a beat");

endmodule

### hw/rtl/rsa_me_dp.sv
// datapath: input reduction, bit-serial modular multiplier, accumulator and base registers
module rsa_me_dp #(
  parameter int WORD_BITS = rsa_me_pkg::DEF_WORD_BITS
) (
  input  logic                 clk,
  input  rsa_me_pkg::dp_cmd_t  cmd,
  input  logic                 action,
  input  logic [WORD_BITS-1:0] message,
  input  logic [WORD_BITS-1:0] pub_exp,
  input  logic [WORD_BITS-1:0] priv_exp,
  input  logic [WORD_BITS-1:0] modulus,
  output logic                 ex_bit,
  output logic [WORD_BITS-1:0] acc_out
);
  import rsa_me_pkg::*;

  function automatic logic [WORD_BITS-1:0] add_mod(
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] b,
    input logic [WORD_BITS-1:0] n
  );
    logic [WORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[WORD_BITS-1:0];
  endfunction

  logic [WORD_BITS-1:0] msg_sh, red, acc, base, ex;
  logic [WORD_BITS-1:0] mx, my, mp;
  logic [WORD_BITS:0]   red_wide;
  logic [WORD_BITS-1:0] red_next, mp_next, mx_next;

  // one quotient bit per cycle, remainder kept below the modulus
  always_comb begin
    red_wide = {red, msg_sh[WORD_BITS-1]};
    if (red_wide >= {1'b0, modulus}) red_wide = red_wide - {1'b0, modulus};
    red_next = red_wide[WORD_BITS-1:0];
  end

  assign mp_next = my[0] ? add_mod(mp, mx, modulus) : mp;
  assign mx_next = add_mod(mx, mx, modulus);

  assign ex_bit  = ex[0];
  assign acc_out = acc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      msg_sh <= message;
      red    <= '0;
      acc    <= WORD_BITS'(1);
      ex     <= action ? priv_exp : pub_exp;
    end
    if (cmd.red_step) begin
      red    <= red_next;
      msg_sh <= {msg_sh[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.red_done) base <= red_next;
    if (cmd.wr_acc) acc <= mp_next;
    if (cmd.wr_base) begin
      base <= mp_next;
      ex   <= {1'b0, ex[WORD_BITS-1:1]};
    end
    if (cmd.mul_start) begin
      mx <= cmd.mul_sqr ? base : acc;
      my <= base;
      mp <= '0;
    end else if (cmd.mul_step) begin
      mx <= mx_next;
      my <= {1'b0, my[WORD_BITS-1:1]};
      mp <= mp_next;
    end
  end

endmodule

### hw/rtl/rsa_modular_exponentiation_core.sv
// top level: configuration registers, result register, controller and datapath
// sequence per beat: load, bit-serial input reduction, then for each exponent bit a multiply
//   into the accumulator when the bit is set and a squaring of the base, then result hand-off
// modulus below two skips the reduction and the scan and finishes with a zero result
// one beat in flight; the next beat is taken while a finished result waits on the output
// synchronous active-high reset restores exponents 65537 and 0, modulus 2, output empty
module rsa_modular_exponentiation_core #(
  parameter int WORD_BITS = rsa_me_pkg::DEF_WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [WORD_BITS-1:0]              message,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [WORD_BITS-1:0]              result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsa_me_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [WORD_BITS-1:0]              cfg_data
);
  import rsa_me_pkg::*;

  logic [WORD_BITS-1:0] pub_exp, priv_exp, modulus;
  logic [WORD_BITS-1:0] acc;
  logic                 ex_bit;
  dp_cmd_t              cmd;
  dp_status_t           status;

  assign cfg_ready = 1'b1;

  assign status.ex_bit   = ex_bit;
  assign status.n_small  = (modulus[WORD_BITS-1:1] == '0);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pub_exp  <= WORD_BITS'(RESET_PUB_EXP);
      priv_exp <= WORD_BITS'(RESET_PRIV_EXP);
      modulus  <= WORD_BITS'(RESET_MODULUS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_PUB_EXP:  pub_exp  <= cfg_data;
        REG_PRIV_EXP: priv_exp <= cfg_data;
        REG_MODULUS:  modulus  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) result <= status.n_small ? '0 : acc;
  end

  rsa_me_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (in_valid),
    .status (status),
    .busy_n (in_ready),
    .cmd    (cmd)
  );

  rsa_me_dp #(
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .action   (action),
    .message  (message),
    .pub_exp  (pub_exp),
    .priv_exp (priv_exp),
    .modulus  (modulus),
    .ex_bit   (ex_bit),
    .acc_out  (acc)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while one is in flight");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("finished result not presented");

endmodule

### sim/rsa_modular_exponentiation_core_tb.sv
// testbench for the rsa exponentiation core: directed table, then predictor-checked random beats
`timescale 1ns / 100ps

module rsa_modular_exponentiation_core_tb;
  import rsa_me_pkg::*;

  localparam int WB = 64;
  localparam int LIMIT_CYCLES = 8_000_000;
  localparam int HOLD_CYCLES = 20_000;
  localparam int TAIL_CYCLES = 9_000;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [WB-1:0] ALL_ONES = '1;
  localparam logic [WB-1:0] PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;

  typedef enum logic {ENCRYPT = 1'b0, DECRYPT = 1'b1} action_e;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_ADDR_W-1:0] sel;
    logic [WB-1:0]         data;
    logic                  known;
    logic [WB-1:0]         want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  action;
  logic [WB-1:0]         message;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [WB-1:0]         result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [WB-1:0]         cfg_data;

  logic [WB-1:0] cur_pub_exp;
  logic [WB-1:0] cur_priv_exp;
  logic [WB-1:0] cur_modulus;
  logic [WB-1:0] expected_results[$];
  stim_row_t     stim_rows[$];

  int mode = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycles = 0;

  rsa_modular_exponentiation_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .message   (message),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [WB-1:0] modmul(input logic [WB-1:0] a, input logic [WB-1:0] b,
                                           input logic [WB-1:0] n);
    logic [2*WB-1:0] p;
    p = {{WB{1'b0}}, a} * {{WB{1'b0}}, b};
    p = p % {{WB{1'b0}}, n};
    return p[WB-1:0];
  endfunction

  function automatic logic [WB-1:0] modexp(input logic [WB-1:0] msg, input logic [WB-1:0] ex,
                                           input logic [WB-1:0] n);
    logic [WB-1:0] acc;
    logic [WB-1:0] sq;
    if (n < 2)
      return '0;
    acc = 1;
    sq = msg % n;
    for (int i = 0; i < WB; i++) begin
      if (ex[i])
        acc = modmul(acc, sq, n);
      sq = modmul(sq, sq, n);
    end
    return acc;
  endfunction

  function automatic logic [WB-1:0] predict_result(input logic act, input logic [WB-1:0] msg);
    return modexp(msg, (act == DECRYPT) ? cur_priv_exp : cur_pub_exp, cur_modulus);
  endfunction

  function automatic void add_cfg(input logic [CFG_ADDR_W-1:0] sel, input logic [WB-1:0] val);
    stim_rows.push_back('{1'b1, sel, val, 1'b0, '0});
  endfunction

  function automatic void add_item(input action_e act, input logic [WB-1:0] msg);
    stim_rows.push_back('{1'b0, {1'b0, act}, msg, 1'b0, '0});
  endfunction

  function automatic void add_check(input action_e act, input logic [WB-1:0] msg,
                                    input logic [WB-1:0] want);
    stim_rows.push_back('{1'b0, {1'b0, act}, msg, 1'b1, want});
  endfunction

  function automatic logic [WB-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WB-1:0] pick_modulus();
    case ($urandom_range(9))
      0: return WB'($urandom_range(2));
      1: return ALL_ONES;
      2: return WB'($urandom_range(65535, 2));
      default: return rand64();
    endcase
  endfunction

  function automatic logic [WB-1:0] pick_exponent();
    case ($urandom_range(7))
      0: return '0;
      1: return ALL_ONES;
      2: return WB'($urandom_range(255));
      default: return rand64();
    endcase
  endfunction

  function automatic logic [WB-1:0] pick_message(input logic [WB-1:0] n);
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2: return n - 1;
      3: return n;
      4: return (n > 1) ? rand64() % n : rand64();
      default: return rand64();
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [WB-1:0] want,
                               input logic [WB-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at cycle %0d: expected %h, got %h", what, cycles, want, got);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] sel, input logic [WB-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= sel;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      REG_PUB_EXP:  cur_pub_exp = val;
      REG_PRIV_EXP: cur_priv_exp = val;
      REG_MODULUS:  cur_modulus = val;
      default: ;
    endcase
  endtask

  task automatic send_item(input logic act, input logic [WB-1:0] msg, input logic known,
                           input logic [WB-1:0] want);
    int gap;
    int pct;
    gap = 0;
    pct = (mode == 0) ? 37 : (mode == 1) ? 80 : 0;
    while (gap < 40 && $urandom_range(99) < pct)
      gap++;
    if (mode == 1 && $urandom_range(7) == 0)
      gap += $urandom_range(9000);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    message <= msg;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(known ? want : predict_result(act, msg));
  endtask

  // receiver: random stalls in modes 0 and 1, none in mode 2, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= ((mode == 0) ? 80 : (mode == 1) ? 37 : 0));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0)
        note_mismatch("beat with nothing expected", '0, result);
      else if (result !== expected_results[0])
        note_mismatch("result", expected_results.pop_front(), result);
      else
        void'(expected_results.pop_front());
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic          cfg_open;
    logic [WB-1:0] pe;
    logic [WB-1:0] de;
    logic [WB-1:0] nm;
    stim_row_t     r;

    rst = 1'b1;
    in_valid = 1'b0;
    action = 1'b0;
    message = '0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    cur_pub_exp = RESET_PUB_EXP;
    cur_priv_exp = RESET_PRIV_EXP;
    cur_modulus = RESET_MODULUS;
    cfg_open = 1'b0;

    // reset settings: modulus two, public exponent 65537, private exponent zero
    add_check(ENCRYPT, '0, 64'd0);
    add_check(ENCRYPT, 64'd1, 64'd1);
    add_check(ENCRYPT, ALL_ONES, 64'd1);
    add_check(DECRYPT, ALL_ONES, 64'd1);
    add_cfg(REG_UNUSED, ALL_ONES);
    add_check(ENCRYPT, 64'd2, 64'd0);
    // degenerate moduli
    add_cfg(REG_MODULUS, '0);
    add_check(DECRYPT, 64'd5, 64'd0);
    add_cfg(REG_MODULUS, 64'd1);
    add_check(ENCRYPT, ALL_ONES, 64'd0);
    // widest modulus and exponent
    add_cfg(REG_MODULUS, ALL_ONES);
    add_cfg(REG_PUB_EXP, ALL_ONES);
    add_check(ENCRYPT, ALL_ONES, 64'd0);
    add_check(ENCRYPT, ALL_ONES - 1, ALL_ONES - 1);
    add_check(DECRYPT, 64'hDEAD_BEEF, 64'd1);
    add_item(ENCRYPT, 64'h8000_0000_0000_0001);
    // textbook key pair
    add_cfg(REG_MODULUS, 64'd3233);
    add_cfg(REG_PUB_EXP, 64'd17);
    add_cfg(REG_PRIV_EXP, 64'd2753);
    add_check(ENCRYPT, 64'd65, 64'd2790);
    add_check(DECRYPT, 64'd2790, 64'd65);
    add_check(ENCRYPT, 64'd3233, 64'd0);
    add_check(ENCRYPT, 64'd3298, 64'd2790);
    // exponent one and zero over a large prime modulus
    add_cfg(REG_MODULUS, PRIME_64);
    add_cfg(REG_PUB_EXP, 64'd1);
    add_check(ENCRYPT, ALL_ONES, 64'h3A);
    add_item(DECRYPT, 64'h1234_5678_9ABC_DEF0);
    add_cfg(REG_PRIV_EXP, ALL_ONES);
    add_item(DECRYPT, 64'h8000_0000_0000_0000);
    add_cfg(REG_PUB_EXP, '0);
    add_check(ENCRYPT, '0, 64'd1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      if (r.is_cfg) begin
        if (!cfg_open)
          drain();
        cfg_write(r.sel, r.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(r.sel[0], r.data, r.known, r.want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      mode <= ph;
      for (int half = 0; half < 2; half++) begin
        pe = pick_exponent();
        de = pick_exponent();
        nm = pick_modulus();
        // first setting keeps the block slow so the hold-off fills it up
        if (ph == 0 && half == 0)
          nm[WB-1] = 1'b1;
        drain();
        cfg_write(REG_PUB_EXP, pe);
        cfg_write(REG_PRIV_EXP, de);
        cfg_write(REG_MODULUS, nm);
        cfg_valid <= 1'b0;
        if (ph == 0 && half == 0)
          hold_reqs <= hold_reqs + 1;
        repeat (14)
          send_item($urandom_range(1), pick_message(nm), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rsa_me_pkg.sv
hw/rtl/rsa_me_ctrl.sv
hw/rtl/rsa_me_dp.sv
hw/rtl/rsa_modular_exponentiation_core.sv
sim/rsa_modular_exponentiation_core_tb.sv
